/* design/ppm_pkg.sv */
// ----------------------------------------------------------------------------
// PPM P3 parser package
// Shared types and constants for the ASCII pixel parser.
// ----------------------------------------------------------------------------
package ppm_pkg;

   localparam int DIM_W   = 13;
   localparam int ACC_W   = 32;
   localparam int MAX_DIM = 4096;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_P     = 8'h50;

   typedef enum logic [2:0] {
      ST_MAGIC_P    = 3'd0,
      ST_MAGIC_3    = 3'd1,
      ST_MAGIC_REST = 3'd2,
      ST_WIDTH      = 3'd3,
      ST_HEIGHT     = 3'd4,
      ST_MAXVAL     = 3'd5,
      ST_PIXELS     = 3'd6,
      ST_DONE       = 3'd7
   } stage_type;

   typedef enum logic [1:0] {
      PH_PRE_SIGN = 2'd0,
      PH_SIGNED   = 2'd1,
      PH_DIGITS   = 2'd2,
      PH_ENDED    = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER    = 3'd0,
      KIND_PIXEL     = 3'd1,
      KIND_BAD_MAGIC = 3'd2,
      KIND_TOO_LARGE = 3'd3,
      KIND_TRUNCATED = 3'd4
   } kind_type;

   // token number state, atoi style
   typedef struct packed {
      phase_type          phase;
      logic               negative;
      logic [ACC_W-1:0]   acc;
   } num_type;

   typedef struct packed {
      logic               valid;
      kind_type           kind;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic               last;
   } result_type;

endpackage

/* design/ppm_num.sv */
// ----------------------------------------------------------------------------
// PPM token number accumulator
// Folds one token character into the atoi-style number state.
// ----------------------------------------------------------------------------
module ppm_num (
   input  logic             token_start,
   input  logic [7:0]       data_char,
   input  ppm_pkg::num_type num_cur,
   output ppm_pkg::num_type num_next
);
   import ppm_pkg::*;

   num_type          base;
   logic             is_digit;
   logic [3:0]       digit;
   logic [ACC_W-1:0] acc_times_ten;

   always_comb begin
      if (token_start) begin
         base = '{phase: PH_PRE_SIGN, negative: 1'b0, acc: '0};
      end else begin
         base = num_cur;
      end
   end

   assign is_digit      = (data_char >= CH_ZERO) && (data_char <= CH_NINE);
   assign digit         = data_char[3:0];
   // acc * 10 + d, wraps mod 2^32
   assign acc_times_ten = {base.acc[ACC_W-4:0], 3'b000} + {base.acc[ACC_W-2:0], 1'b0}
                          + {{(ACC_W-4){1'b0}}, digit};

   always_comb begin
      num_next = base;
      unique case (base.phase)
         PH_PRE_SIGN: begin
            if ((data_char == CH_CR) || (data_char == CH_VT) || (data_char == CH_FF)) begin
               num_next = base;
            end else if ((data_char == CH_PLUS) || (data_char == CH_MINUS)) begin
               num_next.negative = (data_char == CH_MINUS);
               num_next.phase    = PH_SIGNED;
            end else if (is_digit) begin
               num_next.acc   = {{(ACC_W-4){1'b0}}, digit};
               num_next.phase = PH_DIGITS;
            end else begin
               num_next.phase = PH_ENDED;
            end
         end
         PH_SIGNED, PH_DIGITS: begin
            if (is_digit) begin
               num_next.acc   = acc_times_ten;
               num_next.phase = PH_DIGITS;
            end else begin
               num_next.phase = PH_ENDED;
            end
         end
         PH_ENDED: begin
            num_next = base;
         end
      endcase
   end

endmodule

/* design/ppm_ascii_pixel_parser_unit.sv */
// ----------------------------------------------------------------------------
// PPM P3 ASCII pixel parser
// Parses a plain-text P3 image file one byte per item into header, pixel
// and error results.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle, every cycle, as long as the result
// register is empty or is being drained in the same cycle. Each byte is
// parsed in the cycle it is accepted (token split, atoi-style accumulate,
// field dispatch); a result it causes is registered, shows on the rsp side in the
// next cycle and stays until taken. Mark the first byte of a file with req_tuser and
// the last with req_tlast; a file that ends early gives a truncated result.
module ppm_ascii_pixel_parser_unit #(
   parameter int DIM_LIMIT = ppm_pkg::MAX_DIM
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // first_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // image_width[12:0], image_height[25:13], red[33:26],
                                    // green[41:34], blue[49:42], alpha[57:50], zero[63:58]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast    // last_pixel
);
   import ppm_pkg::*;

   // parse state
   stage_type        stage_ff,  stage_in;
   logic             inside_ff, inside_in;
   num_type          num_ff,    num_in;
   logic [DIM_W-1:0] width_ff,  width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [1:0]       chan_ff,   chan_in;
   logic [7:0]       red_ff,    red_in;
   logic [7:0]       green_ff,  green_in;
   logic [DIM_W-1:0] col_ff,    col_in;
   logic [DIM_W-1:0] row_ff,    row_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_res_ff;

   logic             accept;
   logic [7:0]       data_char;
   logic             is_sep;

   stage_type        cur_stage;
   logic             cur_inside;
   num_type          num_fed;

   stage_type        stage_a;
   logic             inside_a;
   num_type          num_a;
   logic             bad_magic;
   logic             close_main;
   logic             close_final;
   logic             do_close;
   stage_type        stage_c;

   logic [ACC_W-1:0] value;
   logic             value_neg;
   logic             value_big;
   logic [DIM_W-1:0] dim;
   logic             empty_image;
   logic [DIM_W:0]   col_inc;
   logic [DIM_W:0]   row_inc;
   logic             is_last;
   logic             col_wrap;

   result_type       res;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign data_char  = req_tdata;
   assign is_sep     = (data_char == CH_SPACE) || (data_char == CH_LF) || (data_char == CH_TAB);

   // first byte restarts the parse
   assign cur_stage  = req_tuser ? ST_MAGIC_P : stage_ff;
   assign cur_inside = req_tuser ? 1'b0 : inside_ff;

   ppm_num u_num (
      .token_start (!cur_inside),
      .data_char   (data_char),
      .num_cur     (num_ff),
      .num_next    (num_fed)
   );

   // byte step: magic check, token split
   always_comb begin
      stage_a    = cur_stage;
      inside_a   = cur_inside;
      num_a      = num_ff;
      bad_magic  = 1'b0;
      close_main = 1'b0;
      unique case (cur_stage)
         ST_MAGIC_P: begin
            if (data_char == CH_P) begin
               stage_a = ST_MAGIC_3;
            end else begin
               stage_a   = ST_DONE;
               bad_magic = 1'b1;
            end
         end
         ST_MAGIC_3: begin
            if (data_char == CH_THREE) begin
               stage_a        = ST_MAGIC_REST;
               inside_a       = 1'b1;
               num_a.phase    = PH_ENDED;
            end else begin
               stage_a   = ST_DONE;
               bad_magic = 1'b1;
            end
         end
         ST_DONE: begin
            stage_a = ST_DONE;
         end
         default: begin
            if (is_sep) begin
               if (cur_inside) begin
                  inside_a   = 1'b0;
                  close_main = 1'b1;
               end
            end else begin
               inside_a = 1'b1;
               num_a    = num_fed;
            end
         end
      endcase
   end

   // token close: final byte closes a token left open
   assign close_final = req_tlast && inside_a && (stage_a != ST_MAGIC_P)
                        && (stage_a != ST_MAGIC_3) && (stage_a != ST_DONE);
   assign do_close    = close_main || close_final;

   assign value       = num_a.negative ? (ACC_W'(0) - num_a.acc) : num_a.acc;
   assign value_neg   = value[ACC_W-1];
   assign value_big   = !value_neg && (value > ACC_W'(DIM_LIMIT));
   assign dim         = value_neg ? '0 : value[DIM_W-1:0];
   assign empty_image = (width_ff == '0) || (dim == '0);

   assign col_inc  = {1'b0, col_ff} + (DIM_W+1)'(1);
   assign row_inc  = {1'b0, row_ff} + (DIM_W+1)'(1);
   assign is_last  = (col_inc == {1'b0, width_ff}) && (row_inc == {1'b0, height_ff});
   assign col_wrap = (col_inc[DIM_W-1:0] >= width_ff);

   // next state
   always_comb begin
      stage_c   = stage_a;
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (do_close) begin
         unique case (stage_a)
            ST_MAGIC_REST: begin
               stage_c = ST_WIDTH;
            end
            ST_WIDTH: begin
               if (value_big) begin
                  stage_c = ST_DONE;
               end else begin
                  width_in = dim;
                  stage_c  = ST_HEIGHT;
               end
            end
            ST_HEIGHT: begin
               if (value_big) begin
                  stage_c = ST_DONE;
               end else begin
                  height_in = dim;
                  stage_c   = empty_image ? ST_DONE : ST_MAXVAL;
               end
            end
            ST_MAXVAL: begin
               stage_c = ST_PIXELS;
               chan_in = 2'd0;
               col_in  = '0;
               row_in  = '0;
            end
            ST_PIXELS: begin
               if (chan_ff == 2'd0) begin
                  red_in  = value[7:0];
                  chan_in = 2'd1;
               end else if (chan_ff == 2'd1) begin
                  green_in = value[7:0];
                  chan_in  = 2'd2;
               end else begin
                  chan_in = 2'd0;
                  if (is_last) begin
                     stage_c = ST_DONE;
                  end else if (col_wrap) begin
                     col_in = '0;
                     row_in = row_inc[DIM_W-1:0];
                  end else begin
                     col_in = col_inc[DIM_W-1:0];
                  end
               end
            end
            default: begin
               stage_c = stage_a;
            end
         endcase
      end
      stage_in  = req_tlast ? ST_DONE : stage_c;
      inside_in = req_tlast ? 1'b0 : inside_a;
      num_in    = num_a;
   end

   // result
   always_comb begin
      res       = '0;
      res.kind  = KIND_HEADER;
      if (do_close) begin
         unique case (stage_a)
            ST_WIDTH: begin
               if (value_big) begin
                  res.valid = 1'b1;
                  res.kind  = KIND_TOO_LARGE;
               end
            end
            ST_HEIGHT: begin
               res.valid = 1'b1;
               if (value_big) begin
                  res.kind = KIND_TOO_LARGE;
               end else begin
                  res.kind   = KIND_HEADER;
                  res.width  = width_ff;
                  res.height = dim;
                  res.last   = empty_image;
               end
            end
            ST_PIXELS: begin
               if ((chan_ff != 2'd0) && (chan_ff != 2'd1)) begin
                  res.valid  = 1'b1;
                  res.kind   = KIND_PIXEL;
                  res.width  = width_ff;
                  res.height = height_ff;
                  res.red    = red_ff;
                  res.green  = green_ff;
                  res.blue   = value[7:0];
                  res.alpha  = ALPHA_OPAQUE;
                  res.last   = is_last;
               end
            end
            default: begin
               res.valid = 1'b0;
            end
         endcase
      end
      if (bad_magic) begin
         res       = '0;
         res.valid = 1'b1;
         res.kind  = KIND_BAD_MAGIC;
      end
      if (req_tlast) begin
         if ((stage_a == ST_MAGIC_P) || (stage_a == ST_MAGIC_3)) begin
            res       = '0;
            res.valid = 1'b1;
            res.kind  = KIND_BAD_MAGIC;
         end else if ((stage_a != ST_DONE) && (stage_c != ST_DONE)) begin
            // file ended before the image was complete
            res       = '0;
            res.valid = 1'b1;
            res.kind  = KIND_TRUNCATED;
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = res.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= ST_MAGIC_P;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            stage_ff  <= stage_in;
            inside_ff <= inside_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         num_ff    <= num_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         chan_ff   <= chan_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         if (res.valid) begin
            rsp_res_ff <= res;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_res_ff.alpha, rsp_res_ff.blue, rsp_res_ff.green,
                        rsp_res_ff.red, rsp_res_ff.height, rsp_res_ff.width};
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tlast  = rsp_res_ff.last;

endmodule
